/* rtl/bvs_pkg.sv */
// Shared definitions for the battery voltage smoother: sequencer states,
// configuration register indexes, reset values and field widths.
// No dependencies.
package bvs_pkg;

    localparam int WINDOW_DEFAULT = 16;

    localparam int ADC_W      = 12;
    localparam int MV_W       = 16;
    localparam int DELTA_W    = 17;
    localparam int SMOOTH_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MUL_W      = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd4;

    localparam logic [23:0] GAIN_RESET      = 24'd580859;
    localparam logic [10:0] OFFSET_RESET    = 11'd100;
    localparam logic [16:0] COEFF_RESET     = 17'd13107;
    localparam logic [16:0] COEFF_ONE       = 17'd65536;
    localparam logic [15:0] THRESHOLD_RESET = 16'd100;
    localparam logic [15:0] FLOOR_RESET     = 16'd200;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_FILTER_MUL,
        ST_FILTER
    } state_t;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        logic s_ready;
        logic mul_en;
        logic mul_filter;
        logic acc_en;
        logic div_start;
        logic avg_en;
        logic res_en;
    } ctrl_t;

endpackage

/* rtl/bvs_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module bvs_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 5,
    parameter int QUO_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] work_reg;     // dividend bits shift out, quotient bits shift in
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, work_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so its top bit drops cleanly.
            rem_reg  <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            work_reg <= {work_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[QUO_W-1:0];

endmodule

/* rtl/battery_voltage_smoother.sv */
// Inputs are taken one at a time: a new reading is accepted only after the previous
// result has been registered. The serial divider, one quotient bit per cycle over
// the running sum, sets the throughput.
// One shared 25x25 multiplier serves both the ADC scaling and the filter step.
// Reset (synchronous, active low) restores register defaults and clears sum,
// fill count, write index and smoothed value; the reading ring is not cleared.
module battery_voltage_smoother #(
    parameter int WINDOW = bvs_pkg::WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bvs_pkg::ADC_W-1:0]       s_adc_code,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bvs_pkg::MV_W-1:0]        m_smoothed_mv,
    output logic signed [bvs_pkg::DELTA_W-1:0] m_delta_mv,
    output logic                            m_settled,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bvs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bvs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = $clog2(WINDOW * 65535 + 1);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MV_W  = bvs_pkg::MV_W;
    localparam int SM_W  = bvs_pkg::SMOOTH_W;
    localparam int M_W   = bvs_pkg::MUL_W;

    // Configuration registers.
    logic [23:0]        gain_reg;
    logic signed [10:0] offset_reg;
    logic [16:0]        coeff_reg;
    logic [15:0]        thr_reg;
    logic [15:0]        floor_reg;

    // Sequencer.
    bvs_pkg::state_t state_reg, state_next;
    bvs_pkg::ctrl_t  ctrl;

    // Datapath state.
    logic [bvs_pkg::ADC_W-1:0] code_reg;
    logic [MV_W-1:0]           ring_mem [WINDOW];
    logic [MV_W-1:0]           ring_rd_reg;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [IDX_W-1:0]          widx_reg, widx_next;
    logic [SM_W-1:0]           smooth_reg;
    logic [MV_W-1:0]           avg_reg;
    logic signed [2*M_W-1:0]   mul_p_reg;

    logic                      m_valid_reg;
    logic [MV_W-1:0]           smoothed_reg;
    logic [bvs_pkg::DELTA_W-1:0] delta_reg;
    logic                      settled_reg;

    logic out_free;
    logic div_done;
    logic [MV_W-1:0] div_quo;

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= bvs_pkg::GAIN_RESET;
            offset_reg <= bvs_pkg::OFFSET_RESET;
            coeff_reg  <= bvs_pkg::COEFF_RESET;
            thr_reg    <= bvs_pkg::THRESHOLD_RESET;
            floor_reg  <= bvs_pkg::FLOOR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bvs_pkg::CFG_GAIN:      gain_reg   <= cfg_data[23:0];
                bvs_pkg::CFG_OFFSET:    offset_reg <= cfg_data[10:0];
                bvs_pkg::CFG_COEFF:     coeff_reg  <= cfg_data[16:0];
                bvs_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data[15:0];
                bvs_pkg::CFG_FLOOR:     floor_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bvs_pkg::ST_IDLE:       if (s_valid) state_next = bvs_pkg::ST_SCALE;
            bvs_pkg::ST_SCALE:      state_next = bvs_pkg::ST_ACCUM;
            bvs_pkg::ST_ACCUM:      state_next = bvs_pkg::ST_DIVIDE;
            bvs_pkg::ST_DIVIDE:     if (div_done) state_next = bvs_pkg::ST_FILTER_MUL;
            bvs_pkg::ST_FILTER_MUL: state_next = bvs_pkg::ST_FILTER;
            bvs_pkg::ST_FILTER:     if (out_free) state_next = bvs_pkg::ST_IDLE;
            default:                state_next = bvs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            bvs_pkg::ST_IDLE:       ctrl.s_ready = 1'b1;
            bvs_pkg::ST_SCALE:      ctrl.mul_en = 1'b1;
            bvs_pkg::ST_ACCUM: begin
                ctrl.acc_en    = 1'b1;
                ctrl.div_start = 1'b1;
            end
            bvs_pkg::ST_DIVIDE:     ctrl.avg_en = div_done;
            bvs_pkg::ST_FILTER_MUL: begin
                ctrl.mul_en     = 1'b1;
                ctrl.mul_filter = 1'b1;
            end
            bvs_pkg::ST_FILTER:     ctrl.res_en = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bvs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = ctrl.s_ready;

    always_ff @(posedge aclk) begin
        if (s_valid && ctrl.s_ready) begin
            code_reg <= s_adc_code;
        end
    end

    // ---------------- shared multiplier ----------------
    logic [16:0]             coeff_eff;
    logic signed [M_W-1:0]   diff;
    logic signed [M_W-1:0]   mul_a, mul_b;

    assign coeff_eff = (coeff_reg > bvs_pkg::COEFF_ONE) ? bvs_pkg::COEFF_ONE : coeff_reg;
    assign diff = $signed({1'b0, avg_reg, 8'h00}) - $signed({1'b0, smooth_reg});

    always_comb begin
        if (ctrl.mul_filter) begin
            mul_a = diff;
            mul_b = $signed({8'h00, coeff_eff});
        end else begin
            mul_a = $signed({13'h0000, code_reg});
            mul_b = $signed({1'b0, gain_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            mul_p_reg <= mul_a * mul_b;
        end
    end

    // ---------------- scaling and window accumulation ----------------
    logic [19:0]        scaled;
    logic signed [21:0] rd_sum;
    logic [MV_W-1:0]    reading;
    logic               ring_full;

    assign scaled = mul_p_reg[35:16];
    assign rd_sum = $signed({2'b00, scaled}) + $signed({{11{offset_reg[10]}}, offset_reg});

    always_comb begin
        if (rd_sum < 0) begin
            reading = '0;
        end else if (rd_sum > 22'sd65535) begin
            reading = '1;
        end else begin
            reading = rd_sum[MV_W-1:0];
        end
    end

    assign ring_full = fill_reg >= CNT_W'(WINDOW);

    always_comb begin
        if (ring_full) begin
            sum_next  = sum_reg + SUM_W'(reading) - SUM_W'(ring_rd_reg);
            fill_next = fill_reg;
        end else begin
            sum_next  = sum_reg + SUM_W'(reading);
            fill_next = fill_reg + 1'b1;
        end
        if ((IDX_W + 1)'(widx_reg) + 1'b1 >= (IDX_W + 1)'(WINDOW)) begin
            widx_next = '0;
        end else begin
            widx_next = widx_reg + 1'b1;
        end
    end

    // Ring read is registered; the write index does not move between the
    // read and the accumulate step, so the oldest reading is ready in time.
    always_ff @(posedge aclk) begin
        ring_rd_reg <= ring_mem[widx_reg];
        if (ctrl.acc_en) begin
            ring_mem[widx_reg] <= reading;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            fill_reg <= '0;
            widx_reg <= '0;
        end else if (ctrl.acc_en) begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            widx_reg <= widx_next;
        end
    end

    bvs_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .QUO_W (MV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.avg_en) begin
            avg_reg <= div_quo;
        end
    end

    // ---------------- filter step and result ----------------
    logic signed [33:0] step;
    logic signed [33:0] nv_raw;
    logic [SM_W-1:0]    nv;
    logic signed [SM_W:0] d;
    logic [SM_W:0]      mag_full;
    logic [SM_W-1:0]    mag;
    logic [MV_W-1:0]    mag_mv;

    // The product shifted right arithmetically is the floor of prod / 65536.
    assign step   = $signed(mul_p_reg[49:16]);
    assign nv_raw = $signed({10'h000, smooth_reg}) + step;

    always_comb begin
        if (nv_raw < 0) begin
            nv = '0;
        end else if (nv_raw > 34'sh0FFFFFF) begin
            nv = '1;
        end else begin
            nv = nv_raw[SM_W-1:0];
        end
    end

    assign d        = $signed({1'b0, nv}) - $signed({1'b0, smooth_reg});
    assign mag_full = d[SM_W] ? (SM_W + 1)'(-d) : d;
    assign mag      = mag_full[SM_W-1:0];
    assign mag_mv   = mag[SM_W-1:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.res_en) begin
                smooth_reg  <= (nv < {floor_reg, 8'h00}) ? '0 : nv;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.res_en) begin
            smoothed_reg <= (nv < {floor_reg, 8'h00}) ? '0 : nv[SM_W-1:8];
            delta_reg    <= d[SM_W] ? bvs_pkg::DELTA_W'(-{1'b0, mag_mv}) : {1'b0, mag_mv};
            settled_reg  <= mag < {thr_reg, 8'h00};
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_smoothed_mv = smoothed_reg;
    assign m_delta_mv    = $signed(delta_reg);
    assign m_settled     = settled_reg;

endmodule
